// ===== rtl/core/point_near_triangle_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// point_near_triangle_test_core_assert
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef POINT_NEAR_TRIANGLE_TEST_CORE_ASSERT_SVH
`define POINT_NEAR_TRIANGLE_TEST_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define PNTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// sequence seq implies cons in the cycle after its end
`define PNTT_ASSERT_AFTER(lbl, seq, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) seq |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pntt_pkg.sv =====
// ----------------------------------------------------------------------------
// pntt_pkg
// shared types and constants of the point near triangle test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pntt_pkg;

  localparam int ThrWidth = 12;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

endpackage

// ===== rtl/core/pntt_edge.sv =====
// ----------------------------------------------------------------------------
// pntt_edge
// distance test of the point against one clamped edge segment, four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pntt_edge #(
  parameter int CW = 16
) (
  input  logic                                  clk,
  input  pntt_pkg::adv_t                        adv,
  input  logic signed [CW:0]                    dx,
  input  logic signed [CW:0]                    dy,
  input  logic signed [CW:0]                    wx,
  input  logic signed [CW:0]                    wy,
  input  logic signed [CW:0]                    vx,
  input  logic signed [CW:0]                    vy,
  input  logic        [2*pntt_pkg::ThrWidth-1:0] thr_sq,
  output logic                                  near
);

  localparam int TW  = pntt_pkg::ThrWidth;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int LW  = 2 * CW + 1;
  localparam int CRB = (2 * TW + LW + 1) / 2;
  localparam int CRE = (CRB < SW) ? CRB : SW;
  localparam int LS  = LW / 2;
  localparam int XW  = 2 * TW + LW + 1;
  localparam int QW  = ((2 * CRE > XW) ? 2 * CRE : XW) + 1;

  // stage 2 products
  logic signed [PW-1:0] p_dxx, p_dyy, p_wxdx, p_wydy, p_wxdy, p_wydx;
  logic signed [PW-1:0] p_wxx, p_wyy, p_vxx, p_vyy;
  // stage 3 sums
  logic        [LW-1:0] len3, ws3, vs3;
  logic signed [SW-1:0] q3, cr3;
  // stage 4 selection
  logic                 cross4;
  logic        [LW-1:0] dsel4, len4;
  logic        [SW-1:0] crabs4;
  logic                 zero_len, pre_start, past;
  // stage 5 products
  logic                      cross5, big5, ptnear5;
  logic [2*CRE-1:0]          crsq5;
  logic [2*TW+LS-1:0]        xlo5;
  logic [2*TW+LW-LS-1:0]     xhi5;
  logic [QW-1:0]             xsum;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p_dxx  <= dx * dx;
      p_dyy  <= dy * dy;
      p_wxdx <= wx * dx;
      p_wydy <= wy * dy;
      p_wxdy <= wx * dy;
      p_wydx <= wy * dx;
      p_wxx  <= wx * wx;
      p_wyy  <= wy * wy;
      p_vxx  <= vx * vx;
      p_vyy  <= vy * vy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      len3 <= p_dxx[LW-1:0] + p_dyy[LW-1:0];
      ws3  <= p_wxx[LW-1:0] + p_wyy[LW-1:0];
      vs3  <= p_vxx[LW-1:0] + p_vyy[LW-1:0];
      q3   <= SW'(p_wxdx) + SW'(p_wydy);
      cr3  <= SW'(p_wxdy) - SW'(p_wydx);
    end
  end

  assign zero_len  = (len3 == '0);
  assign pre_start = (q3 <= $signed({SW{1'b0}}));
  assign past      = (q3 >= $signed({{(SW-LW){1'b0}}, len3}));

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      len4   <= len3;
      crabs4 <= cr3[SW-1] ? (SW'(0) - cr3) : cr3;
      if (zero_len || pre_start) begin
        cross4 <= 1'b0;
        dsel4  <= ws3;
      end else if (past) begin
        cross4 <= 1'b0;
        dsel4  <= vs3;
      end else begin
        cross4 <= 1'b1;
        dsel4  <= ws3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      cross5  <= cross4;
      big5    <= ((crabs4 >> CRE) != '0);
      crsq5   <= crabs4[CRE-1:0] * crabs4[CRE-1:0];
      xlo5    <= thr_sq * len4[LS-1:0];
      xhi5    <= thr_sq * len4[LW-1:LS];
      ptnear5 <= (dsel4 <= thr_sq);
    end
  end

  assign xsum = QW'(xlo5) + (QW'(xhi5) << LS);
  assign near = cross5 ? (!big5 && (QW'(crsq5) <= xsum)) : ptnear5;

endmodule

// ===== rtl/core/point_near_triangle_test_core.sv =====
// ----------------------------------------------------------------------------
// point_near_triangle_test_core
// barycentric point-in-triangle test with an edge distance tolerance
//
//   channel  direction  handshake              words
//   in       in         in_valid / in_stall    point and three vertices
//   out      out        out_valid / out_stall  hit, degenerate_triangle
//   cfg      in         cfg_wr_en              near_threshold
//
// one word per cycle sustained while out_stall is low
// stages: differences, products, sums, sign and clamp select, products, compare
// each stage holds its word while the next is full and stalled
// rst clears all valid bits and sets near_threshold to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_near_triangle_test_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0]       vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0]       vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0]       vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0]       vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0]       vertex_c_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic                                degenerate_triangle,
  input  logic                                cfg_wr_en,
  input  logic        [pntt_pkg::ThrWidth-1:0] cfg_wr_data
);

  localparam int TW = pntt_pkg::ThrWidth;
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int AW = SW + 3;
  localparam int OW = ((FRAC_BITS > TW) ? FRAC_BITS : TW) + 1;
  localparam int BW = SW + TW + FRAC_BITS + 4;

  logic [TW-1:0]   thr;
  logic [2*TW-1:0] thr_sq;
  logic [OW-1:0]   thr_one;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;
  pntt_pkg::adv_t adv;

  // stage 1 differences
  logic signed [DW-1:0] d0x, d0y, d1x, d1y, d2x, d2y;
  logic signed [DW-1:0] w0x, w0y, w1x, w1y, w2x, w2y;
  // stage 2 products
  logic signed [PW-1:0] pk1, pk2, pb1, pb2, pg1, pg2;
  // stage 3 sums
  logic signed [SW-1:0] k3, bn3, gn3;
  // stage 4
  logic                 deg4;
  logic signed [SW:0]   kp4, bn4, gn4;
  logic signed [AW-1:0] an4;
  logic signed [SW:0]   kp_n, bn_n, gn_n;
  // stage 5
  logic                 deg5;
  logic signed [AW-1:0] an5, bn5, gn5;
  logic [TW+SW-1:0]     tk5;
  logic [OW+SW-1:0]     ok5;
  logic                 near0, near1, near2;
  logic                 bary_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= '0;
      thr_sq  <= '0;
      thr_one <= OW'(1) << FRAC_BITS;
    end else if (cfg_wr_en) begin
      thr     <= cfg_wr_data;
      thr_sq  <= cfg_wr_data * cfg_wr_data;
      thr_one <= OW'(cfg_wr_data) + (OW'(1) << FRAC_BITS);
    end
  end

  assign en6      = !out_valid || !out_stall;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign adv      = '{s2: en2, s3: en3, s4: en4, s5: en5};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d0x <= DW'(vertex_b_x) - DW'(vertex_a_x);
      d0y <= DW'(vertex_b_y) - DW'(vertex_a_y);
      d1x <= DW'(vertex_c_x) - DW'(vertex_b_x);
      d1y <= DW'(vertex_c_y) - DW'(vertex_b_y);
      d2x <= DW'(vertex_a_x) - DW'(vertex_c_x);
      d2y <= DW'(vertex_a_y) - DW'(vertex_c_y);
      w0x <= DW'(point_x) - DW'(vertex_a_x);
      w0y <= DW'(point_y) - DW'(vertex_a_y);
      w1x <= DW'(point_x) - DW'(vertex_b_x);
      w1y <= DW'(point_y) - DW'(vertex_b_y);
      w2x <= DW'(point_x) - DW'(vertex_c_x);
      w2y <= DW'(point_y) - DW'(vertex_c_y);
    end
  end

  // c - a is the negated edge d2, which holds a - c
  always_ff @(posedge clk) begin
    if (en2) begin
      pk1 <= d0y * d2x;
      pk2 <= d0x * d2y;
      pb1 <= w0y * d2x;
      pb2 <= w0x * d2y;
      pg1 <= d0x * w0y;
      pg2 <= d0y * w0x;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      k3  <= SW'(pk1) - SW'(pk2);
      bn3 <= SW'(pb1) - SW'(pb2);
      gn3 <= SW'(pg1) - SW'(pg2);
    end
  end

  always_comb begin
    if (k3[SW-1]) begin
      kp_n = -(SW+1)'(k3);
      bn_n = -(SW+1)'(bn3);
      gn_n = -(SW+1)'(gn3);
    end else begin
      kp_n = (SW+1)'(k3);
      bn_n = (SW+1)'(bn3);
      gn_n = (SW+1)'(gn3);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      deg4 <= (k3 == '0);
      kp4  <= kp_n;
      bn4  <= bn_n;
      gn4  <= gn_n;
      an4  <= AW'(kp_n) - AW'(bn_n) - AW'(gn_n);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      deg5 <= deg4;
      an5  <= an4;
      bn5  <= AW'(bn4);
      gn5  <= AW'(gn4);
      tk5  <= thr * kp4[SW-1:0];
      ok5  <= thr_one * kp4[SW-1:0];
    end
  end

  function automatic logic bary_in(input logic signed [AW-1:0] x,
                                   input logic [TW+SW-1:0] tk,
                                   input logic [OW+SW-1:0] ok);
    logic signed [BW-1:0] xs, lo, hi;
    xs = BW'(x) <<< FRAC_BITS;
    lo = -$signed(BW'(tk));
    hi = $signed(BW'(ok));
    return (lo <= xs) && (xs <= hi);
  endfunction

  assign bary_hit = !deg5 && bary_in(an5, tk5, ok5) && bary_in(bn5, tk5, ok5)
                    && bary_in(gn5, tk5, ok5);

  pntt_edge #(.CW(CW)) u_edge_ab (
    .clk(clk), .adv(adv), .dx(d0x), .dy(d0y), .wx(w0x), .wy(w0y),
    .vx(w1x), .vy(w1y), .thr_sq(thr_sq), .near(near0)
  );

  pntt_edge #(.CW(CW)) u_edge_bc (
    .clk(clk), .adv(adv), .dx(d1x), .dy(d1y), .wx(w1x), .wy(w1y),
    .vx(w2x), .vy(w2y), .thr_sq(thr_sq), .near(near1)
  );

  pntt_edge #(.CW(CW)) u_edge_ca (
    .clk(clk), .adv(adv), .dx(d2x), .dy(d2y), .wx(w2x), .wy(w2y),
    .vx(w0x), .vy(w0y), .thr_sq(thr_sq), .near(near2)
  );

  always_ff @(posedge clk) begin
    if (en6) begin
      hit                 <= bary_hit || near0 || near1 || near2;
      degenerate_triangle <= deg5;
    end
  end

endmodule

// ===== rtl/core/pntt_checker.sv =====
// ----------------------------------------------------------------------------
// pntt_checker
// port level checks of the point near triangle test core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_near_triangle_test_core_assert.svh"

module pntt_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [COORD_WIDTH-1:0]       point_x,
  input logic signed [COORD_WIDTH-1:0]       point_y,
  input logic signed [COORD_WIDTH-1:0]       vertex_a_x,
  input logic signed [COORD_WIDTH-1:0]       vertex_a_y,
  input logic signed [COORD_WIDTH-1:0]       vertex_b_x,
  input logic signed [COORD_WIDTH-1:0]       vertex_b_y,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                hit,
  input logic                                degenerate_triangle
);

  logic       in_acc;
  logic       out_wait;
  logic [1:0] out_word;
  logic       out_deg;
  logic       out_hit;
  logic       acc_ab_same;
  logic       acc_on_a;

  // consecutive cycles with the output side free
  sequence s_flow;
    (!out_stall) [*5];
  endsequence

  assign in_acc      = in_valid && !in_stall;
  assign out_wait    = out_valid && out_stall;
  assign out_word    = {hit, degenerate_triangle};
  assign out_deg     = out_valid && degenerate_triangle;
  assign out_hit     = out_valid && hit;
  assign acc_ab_same = in_acc && (vertex_a_x == vertex_b_x) && (vertex_a_y == vertex_b_y);
  assign acc_on_a    = in_acc && (point_x == vertex_a_x) && (point_y == vertex_a_y);

  `PNTT_ASSERT_AFTER(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled word changed")

  `PNTT_ASSERT_NOW(a_empty_ready, !out_valid, !in_stall, "input stalled with empty output")

  `PNTT_ASSERT_AFTER(a_degen, acc_ab_same ##1 s_flow, out_deg, "coincident vertices not flagged")

  `PNTT_ASSERT_AFTER(a_vertex_hit, acc_on_a ##1 s_flow, out_hit, "point on a vertex missed")

endmodule

bind point_near_triangle_test_core pntt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pntt_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the point near triangle test against a predictor built on exact
// wide integer arithmetic, with random idling on both sides of the pipeline
// and the near threshold changed between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 16;
  localparam int FB = 4;
  localparam int LATENCY = 6;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t px, py, ax, ay, bx, by, cx, cy;
  } tri_word_t;

  typedef struct packed {
    logic hit;
    logic degenerate;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tri_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic degenerate_triangle;
  logic cfg_wr_en = 1'b0;
  logic [pntt_pkg::ThrWidth-1:0] cfg_wr_data = '0;

  tri_word_t pending_words[$];
  verdict_t expected_verdicts[$];
  logic [pntt_pkg::ThrWidth-1:0] threshold = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic stim_done = 1'b0;

  always #5 clk = ~clk;

  point_near_triangle_test_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(in_word.px), .point_y(in_word.py),
    .vertex_a_x(in_word.ax), .vertex_a_y(in_word.ay),
    .vertex_b_x(in_word.bx), .vertex_b_y(in_word.by),
    .vertex_c_x(in_word.cx), .vertex_c_y(in_word.cy),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .degenerate_triangle(degenerate_triangle),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic near_edge(longint px, longint py, longint sx, longint sy,
                                     longint ex, longint ey, longint t);
    longint dx, dy, wx, wy, len, q, vx, vy;
    logic signed [127:0] cr;
    dx = ex - sx; dy = ey - sy;
    wx = px - sx; wy = py - sy;
    len = dx * dx + dy * dy;
    q = wx * dx + wy * dy;
    if (len == 0 || q <= 0) return (wx * wx + wy * wy) <= t * t;
    if (q >= len) begin
      vx = px - ex; vy = py - ey;
      return (vx * vx + vy * vy) <= t * t;
    end
    cr = 128'(wx * dy - wy * dx);
    return cr * cr <= 128'(t * t) * 128'(len);
  endfunction

  function automatic logic bary_ok(longint x, longint k, longint t);
    logic signed [127:0] xs, lo, hi;
    xs = 128'(x) * 128'(1 << FB);
    lo = -128'(t) * 128'(k);
    hi = 128'((1 << FB) + t) * 128'(k);
    return (lo <= xs) && (xs <= hi);
  endfunction

  function automatic verdict_t classify(tri_word_t w, longint t);
    longint px, py, ax, ay, bx, by, cx, cy, k, bn, gn, an;
    verdict_t v;
    px = w.px; py = w.py; ax = w.ax; ay = w.ay;
    bx = w.bx; by = w.by; cx = w.cx; cy = w.cy;
    k = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    v.degenerate = (k == 0);
    v.hit = 1'b0;
    if (k != 0) begin
      bn = (px - ax) * (cy - ay) - (py - ay) * (cx - ax);
      gn = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      if (k < 0) begin
        k = -k; bn = -bn; gn = -gn;
      end
      an = k - bn - gn;
      v.hit = bary_ok(an, k, t) && bary_ok(bn, k, t) && bary_ok(gn, k, t);
    end
    if (!v.hit)
      v.hit = near_edge(px, py, ax, ay, bx, by, t) || near_edge(px, py, bx, by, cx, cy, t)
              || near_edge(px, py, cx, cy, ax, ay, t);
    return v;
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic tri_word_t rand_word();
    tri_word_t w;
    int span, pick;
    pick = $urandom_range(9);
    span = (pick < 2) ? 0 : (pick < 5) ? 2000 : (pick < 8) ? 200 : 12;
    w.ax = rand_coord(span); w.ay = rand_coord(span);
    w.bx = rand_coord(span); w.by = rand_coord(span);
    w.cx = rand_coord(span); w.cy = rand_coord(span);
    if ($urandom_range(5) == 0) begin
      // collinear or repeated vertices
      w.cx = w.bx + (w.bx - w.ax); w.cy = w.by + (w.by - w.ay);
      if ($urandom_range(1)) begin
        w.bx = w.ax; w.by = w.ay;
      end
    end
    case ($urandom_range(3))
      0: begin
        w.px = rand_coord(span); w.py = rand_coord(span);
      end
      1: begin
        w.px = coord_t'((longint'(w.ax) + w.bx + w.cx) / 3);
        w.py = coord_t'((longint'(w.ay) + w.by + w.cy) / 3);
      end
      default: begin
        // near an edge or a vertex
        w.px = coord_t'((longint'(w.ax) + w.bx) / 2 + $urandom_range(80) - 40);
        w.py = coord_t'((longint'(w.ay) + w.by) / 2 + $urandom_range(80) - 40);
        if ($urandom_range(2) == 0) begin
          w.px = w.cx + coord_t'($urandom_range(60) - 30);
          w.py = w.cy + coord_t'($urandom_range(60) - 30);
        end
      end
    endcase
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_verdicts.push_back(classify(in_word, threshold));
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected word hit=%b degenerate=%b", $time, hit,
                 degenerate_triangle);
        errors++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (exp_v.hit !== hit) begin
          $display("%0t: hit expected %b actual %b", $time, exp_v.hit, hit);
          errors++;
        end
        if (exp_v.degenerate !== degenerate_triangle) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_v.degenerate,
                   degenerate_triangle);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || stim_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (in_valid || expected_verdicts.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_threshold(logic [pntt_pkg::ThrWidth-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    threshold = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_word(coord_t px, coord_t py, coord_t ax, coord_t ay,
                          coord_t bx, coord_t by, coord_t cx, coord_t cy);
    tri_word_t w;
    w = '{px, py, ax, ay, bx, by, cx, cy};
    pending_words.push_back(w);
  endtask

  task automatic add_random(int count);
    repeat (count) pending_words.push_back(rand_word());
  endtask

  localparam coord_t MX = 16'sh7fff;
  localparam coord_t MN = -16'sh8000;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, zero threshold
    add_word(16, 16, 0, 0, 160, 0, 0, 160);
    add_word(500, 500, 0, 0, 160, 0, 0, 160);
    add_word(80, 0, 0, 0, 160, 0, 0, 160);
    add_word(0, 0, 0, 0, 0, 160, 160, 0);
    add_word(MX, MX, MN, MN, MX, MN, MN, MX);
    add_word(MN, MN, MN, MN, MX, MN, MN, MX);
    add_word(0, 0, MX, MX, MN, MN, MX, MN);
    add_word(MX, MN, MN, MX, MX, MX, MN, MN);
    add_word(5, 5, 0, 0, 10, 10, 20, 20);
    add_word(3, 4, 0, 0, 0, 0, 0, 0);
    add_word(0, 0, 0, 0, 0, 0, 0, 0);
    add_word(-1, -1, 0, 0, 0, 0, 0, 0);
    add_word(MN, MX, 7, 7, 7, 7, 7, 7);
    drain();
    write_threshold(12'hfff);
    add_word(3, 4, 0, 0, 0, 0, 0, 0);
    add_word(MX, MX, MN, MN, MX, MN, MN, MX);
    add_word(-300, -300, 0, 0, 160, 0, 0, 160);
    add_word(200, 200, 0, 0, 160, 0, 0, 160);
    add_word(MN, MN, MX, MX, MX, MX, MX, MX);
    drain();
    write_threshold(12'd5);
    add_word(3, 4, 0, 0, 0, 0, 0, 0);
    add_word(3, 5, 0, 0, 0, 0, 0, 0);
    add_word(-4, 80, 0, 0, 0, 160, 160, 0);
    add_word(-6, 80, 0, 0, 0, 160, 160, 0);
    drain();

    send_idle_pct = 14; recv_idle_pct = 76;
    write_threshold(12'd0);
    add_random(200);
    drain();
    write_threshold(12'd20);
    add_random(200);
    drain();

    send_idle_pct = 76; recv_idle_pct = 14;
    write_threshold(12'hfff);
    add_random(150);
    drain();
    write_threshold(12'(48 + $urandom_range(500)));
    add_random(200);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_threshold(12'($urandom));
    add_random(200);
    drain();
    write_threshold(12'd8);
    add_random(200);
    drain();
    stim_done = 1'b1;

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
